// ===== rtl/efs_pkg.sv =====
// Shared types and constants for the eased fade sequencer.
// Holds the transaction structs, opcode and register index codes.
// No dependencies.
`default_nettype none

package efs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_BITS = 16;
  localparam int LEVEL_W   = FRAC_BITS + 1;
  localparam int DUR_W     = 16;
  localparam int TICK_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0]   ONE_LEVEL = LEVEL_W'(1) << FRAC_BITS;
  localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;

  localparam logic [DUR_W-1:0]  FADE_IN_RESET  = DUR_W'(200);
  localparam logic [DUR_W-1:0]  FADE_OUT_RESET = DUR_W'(150);
  localparam logic [TICK_W-1:0] TICK_RESET     = TICK_W'(10);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SHOW = 2'd1,
    OP_HIDE = 2'd2,
    OP_STOP = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FADE_IN  = 2'd0,
    REG_FADE_OUT = 2'd1,
    REG_TICK     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    op_t                op;
    logic [LEVEL_W-1:0] stop_level;
  } cmd_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               finished;
  } rsp_t;

endpackage

`default_nettype wire

// ===== rtl/eased_fade_sequencer.sv =====
// Eased fade sequencer: fade level on an ease-in-out-quad curve. Depends on efs_pkg.
// Show, hide, stop and a finishing tick pass through the emit state into the output register
// (rsp_valid); a tick inside a fade first passes the divide, square and scale steps.
// One transaction at a time: cmd_stall stays high until the result is registered, and longer
// while rsp_stall holds the output register; an ignored command leaves cmd_stall low.
// Reset (synchronous, rst high): idle at level 0, registers back to 200, 150 and 10.
`default_nettype none

module eased_fade_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cmd_valid,
  output logic                                  cmd_stall,
  input  wire efs_pkg::cmd_t                    cmd,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_stall,
  output efs_pkg::rsp_t                         rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [efs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [efs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int LW = efs_pkg::LEVEL_W;
  localparam int FB = efs_pkg::FRAC_BITS;
  localparam int TB = efs_pkg::TIME_BITS;
  localparam int DW = efs_pkg::DUR_W;
  localparam int PW = 2 * LW + 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SQUARE,
    ST_SCALE,
    ST_EMIT
  } state_t;

  state_t state;

  // configuration
  logic [DW-1:0]              fade_in_time;
  logic [DW-1:0]              fade_out_time;
  logic [efs_pkg::TICK_W-1:0] tick_period;

  // fade state
  logic [LW-1:0] current_level;
  logic [LW-1:0] start_level;
  logic [LW-1:0] goal_level;
  logic          running;
  logic [TB-1:0] elapsed_time;
  logic [DW-1:0] fade_duration;

  // serial datapath
  logic [4:0]    step;
  logic [DW-1:0] rem;
  logic [FB-1:0] quo;
  logic [LW-1:0] mul_a;
  logic [PW-1:0] prod;
  logic          ease_low;

  // pending result
  logic [LW-1:0] res_level;
  logic          res_finished;

  // combinational helpers
  logic [TB:0]   elapsed_sum;
  logic [TB-1:0] elapsed_next;
  logic          fade_done;
  logic [DW:0]   rem_shift;
  logic          rem_ge;
  logic [DW:0]   rem_diff;
  logic [FB-1:0] quo_next;
  logic [FB-1:0] fold_q;
  logic [LW-1:0] fold_in;
  logic [LW:0]   prod_sum;
  logic [PW-1:0] prod_next;
  logic [LW-1:0] sq_shift;
  logic [LW-1:0] ease_val;
  logic [LW-1:0] level_span;
  logic [LW-1:0] scaled;
  logic [LW-1:0] fade_level;
  logic [LW-1:0] stop_clamped;
  logic [LW-1:0] show_goal;
  logic [DW-1:0] show_dur;
  logic          is_show;

  always_comb begin
    elapsed_sum  = {1'b0, elapsed_time} + (TB+1)'(tick_period);
    elapsed_next = elapsed_sum[TB] ? efs_pkg::TIME_MAX : elapsed_sum[TB-1:0];
    fade_done    = ((TB+1)'(elapsed_next) >= (TB+1)'(fade_duration)) ||
                   (elapsed_next == efs_pkg::TIME_MAX);

    rem_shift = {rem, 1'b0};
    rem_ge    = rem_shift >= {1'b0, fade_duration};
    rem_diff  = rem_shift - {1'b0, fade_duration};
    quo_next  = {quo[FB-2:0], rem_ge};

    // fold the upper half of the curve onto ONE - progress
    fold_q  = ~quo_next + 1'b1;
    fold_in = quo_next[FB-1] ? {1'b0, fold_q} : {1'b0, quo_next};

    // shift-add: add multiplicand on the low bit, then shift right
    prod_sum  = prod[PW-1:LW] + (prod[0] ? {1'b0, mul_a} : '0);
    prod_next = {prod_sum, prod[LW-1:0]} >> 1;

    // (2*x*x) >> FB == (x*x) >> (FB-1)
    sq_shift = prod_next[FB-1 +: LW];
    ease_val = ease_low ? sq_shift : efs_pkg::ONE_LEVEL - sq_shift;

    level_span = (goal_level >= start_level) ? goal_level - start_level
                                             : start_level - goal_level;
    scaled     = prod_next[FB +: LW];
    fade_level = (goal_level >= start_level) ? start_level + scaled
                                             : start_level - scaled;

    stop_clamped = (cmd.stop_level > efs_pkg::ONE_LEVEL) ? efs_pkg::ONE_LEVEL
                                                         : cmd.stop_level;
    is_show   = (cmd.op == efs_pkg::OP_SHOW);
    show_goal = is_show ? efs_pkg::ONE_LEVEL : '0;
    show_dur  = is_show ? fade_in_time : fade_out_time;
  end

  assign cmd_stall = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      fade_in_time  <= efs_pkg::FADE_IN_RESET;
      fade_out_time <= efs_pkg::FADE_OUT_RESET;
      tick_period   <= efs_pkg::TICK_RESET;
      current_level <= '0;
      start_level   <= '0;
      goal_level    <= '0;
      running       <= 1'b0;
      elapsed_time  <= '0;
      fade_duration <= DW'(1);
      step          <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          efs_pkg::REG_FADE_IN:  fade_in_time  <= cfg_data;
          efs_pkg::REG_FADE_OUT: fade_out_time <= cfg_data;
          efs_pkg::REG_TICK:     tick_period   <= cfg_data[efs_pkg::TICK_W-1:0];
          default: ;
        endcase
      end

      // hold the output register while stalled, drop it once taken
      if (state == ST_EMIT) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            case (cmd.op)
              efs_pkg::OP_SHOW, efs_pkg::OP_HIDE: begin
                if (running && goal_level == show_goal) begin
                  state <= ST_IDLE;
                end else if (!running && current_level == show_goal) begin
                  res_level    <= current_level;
                  res_finished <= 1'b1;
                  state        <= ST_EMIT;
                end else begin
                  start_level   <= current_level;
                  goal_level    <= show_goal;
                  fade_duration <= (show_dur == '0) ? DW'(1) : show_dur;
                  elapsed_time  <= '0;
                  running       <= 1'b1;
                  res_level     <= current_level;
                  res_finished  <= 1'b0;
                  state         <= ST_EMIT;
                end
              end
              efs_pkg::OP_STOP: begin
                running       <= 1'b0;
                current_level <= stop_clamped;
                start_level   <= stop_clamped;
                goal_level    <= stop_clamped;
                res_level     <= stop_clamped;
                res_finished  <= 1'b1;
                state         <= ST_EMIT;
              end
              efs_pkg::OP_TICK: begin
                if (running) begin
                  elapsed_time <= elapsed_next;
                  if (fade_done) begin
                    current_level <= goal_level;
                    running       <= 1'b0;
                    res_level     <= goal_level;
                    res_finished  <= 1'b1;
                    state         <= ST_EMIT;
                  end else begin
                    // elapsed < duration, so the quotient fits FB bits
                    rem   <= DW'(elapsed_next);
                    quo   <= '0;
                    step  <= '0;
                    state <= ST_DIVIDE;
                  end
                end
              end
              default: ;
            endcase
          end
        end

        ST_DIVIDE: begin
          rem <= rem_ge ? rem_diff[DW-1:0] : rem_shift[DW-1:0];
          quo <= quo_next;
          if (step == 5'(FB - 1)) begin
            ease_low <= ~quo_next[FB-1];
            mul_a    <= fold_in;
            prod     <= PW'(fold_in);
            step     <= '0;
            state    <= ST_SQUARE;
          end else begin
            step <= step + 5'd1;
          end
        end

        ST_SQUARE: begin
          if (step == 5'(LW - 1)) begin
            // hand the square over to the scaling multiply
            mul_a <= level_span;
            prod  <= PW'(ease_val);
            step  <= '0;
            state <= ST_SCALE;
          end else begin
            prod <= prod_next;
            step <= step + 5'd1;
          end
        end

        ST_SCALE: begin
          if (step == 5'(LW - 1)) begin
            current_level <= fade_level;
            res_level     <= fade_level;
            res_finished  <= 1'b0;
            step          <= '0;
            state         <= ST_EMIT;
          end else begin
            prod <= prod_next;
            step <= step + 5'd1;
          end
        end

        ST_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp.level    <= res_level;
            rsp.finished <= res_finished;
            state        <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  level_in_range: assert property (@(posedge clk) disable iff (rst)
    current_level <= efs_pkg::ONE_LEVEL)
    else $error("fade level above full scale");

  duration_nonzero: assert property (@(posedge clk) disable iff (rst)
    fade_duration != '0)
    else $error("fade duration is zero");

  divide_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIVIDE |-> rem < fade_duration)
    else $error("divider remainder out of range");

  busy_means_running: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE || state == ST_SQUARE || state == ST_SCALE) |-> running)
    else $error("arithmetic pass without a running fade");

  emit_delivers: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && !(rsp_valid && rsp_stall) |=> rsp_valid && state == ST_IDLE)
    else $error("pending result not moved to output register");

endmodule

`default_nettype wire

// ===== dv/efs_checker.sv =====
// Checker for the eased fade sequencer: watches the cmd, rsp and cfg channels,
// predicts every level report and compares it with what the block sends.
// Depends on efs_pkg.
module efs_checker (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cmd_valid,
  input  wire logic                           cmd_stall,
  input  wire efs_pkg::cmd_t                  cmd,
  input  wire logic                           rsp_valid,
  input  wire logic                           rsp_stall,
  input  wire efs_pkg::rsp_t                  rsp,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [efs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [efs_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  mismatches,
  output int                                  outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the registers
  logic [efs_pkg::DUR_W-1:0]     in_ms;
  logic [efs_pkg::DUR_W-1:0]     out_ms;
  logic [efs_pkg::TICK_W-1:0]    tick_ms;

  // Shadow copy of the fade state
  logic [efs_pkg::LEVEL_W-1:0]   lvl;
  logic [efs_pkg::LEVEL_W-1:0]   from_lvl;
  logic [efs_pkg::LEVEL_W-1:0]   to_lvl;
  logic                          fading;
  logic [efs_pkg::TIME_BITS-1:0] elapsed_ms;
  logic [efs_pkg::DUR_W-1:0]     span_ms;

  efs_pkg::rsp_t pending_levels[$];

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= 100)
      $display("[%0t] mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic expect_level(input logic [efs_pkg::LEVEL_W-1:0] value, input logic done);
    efs_pkg::rsp_t r;
    r.level    = value;
    r.finished = done;
    pending_levels.push_back(r);
  endtask

  function automatic logic [efs_pkg::LEVEL_W-1:0] ease_quad_curve(
    input logic [efs_pkg::LEVEL_W-1:0] p);
    logic [efs_pkg::LEVEL_W-1:0]   q;
    logic [2*efs_pkg::LEVEL_W+1:0] sq;
    if (p < (efs_pkg::ONE_LEVEL >> 1)) begin
      sq = p;
      sq = (sq * p) << 1;
      return efs_pkg::LEVEL_W'(sq >> efs_pkg::FRAC_BITS);
    end
    q  = efs_pkg::ONE_LEVEL - p;
    sq = q;
    sq = (sq * q) << 1;
    return efs_pkg::ONE_LEVEL - efs_pkg::LEVEL_W'(sq >> efs_pkg::FRAC_BITS);
  endfunction

  task automatic launch_fade(input logic [efs_pkg::LEVEL_W-1:0] goal,
                             input logic [efs_pkg::DUR_W-1:0] dur);
    // Drop a repeat of the running fade
    if (fading && to_lvl == goal)
      return;
    if (!fading && lvl == goal) begin
      expect_level(lvl, 1'b1);
      return;
    end
    from_lvl   = lvl;
    to_lvl     = goal;
    span_ms    = (dur == '0) ? efs_pkg::DUR_W'(1) : dur;
    elapsed_ms = '0;
    fading     = 1'b1;
    expect_level(lvl, 1'b0);
  endtask

  task automatic advance_fade();
    logic [efs_pkg::TIME_BITS:0]                    sum;
    logic [efs_pkg::TIME_BITS+efs_pkg::FRAC_BITS-1:0] num;
    logic [efs_pkg::TIME_BITS+efs_pkg::FRAC_BITS-1:0] quot;
    logic [efs_pkg::LEVEL_W-1:0]                    prog;
    logic [efs_pkg::LEVEL_W-1:0]                    eased;
    logic [efs_pkg::LEVEL_W-1:0]                    gap_lvl;
    logic [2*efs_pkg::LEVEL_W-1:0]                  prod;
    if (!fading)
      return;
    sum = elapsed_ms + tick_ms;
    elapsed_ms = (sum > efs_pkg::TIME_MAX) ? efs_pkg::TIME_MAX
                                           : sum[efs_pkg::TIME_BITS-1:0];
    if (elapsed_ms >= span_ms || elapsed_ms == efs_pkg::TIME_MAX) begin
      lvl    = to_lvl;
      fading = 1'b0;
      expect_level(lvl, 1'b1);
      return;
    end
    num   = {elapsed_ms, {efs_pkg::FRAC_BITS{1'b0}}};
    quot  = num / span_ms;
    prog  = quot[efs_pkg::LEVEL_W-1:0];
    eased = ease_quad_curve(prog);
    // Round toward the start level in either direction
    if (to_lvl >= from_lvl) begin
      gap_lvl = to_lvl - from_lvl;
      prod    = gap_lvl * eased;
      lvl     = from_lvl + efs_pkg::LEVEL_W'(prod >> efs_pkg::FRAC_BITS);
    end else begin
      gap_lvl = from_lvl - to_lvl;
      prod    = gap_lvl * eased;
      lvl     = from_lvl - efs_pkg::LEVEL_W'(prod >> efs_pkg::FRAC_BITS);
    end
    expect_level(lvl, 1'b0);
  endtask

  task automatic predict_fade_step(input efs_pkg::cmd_t c);
    logic [efs_pkg::LEVEL_W-1:0] v;
    case (c.op)
      efs_pkg::OP_SHOW: launch_fade(efs_pkg::ONE_LEVEL, in_ms);
      efs_pkg::OP_HIDE: launch_fade('0, out_ms);
      efs_pkg::OP_STOP: begin
        v        = (c.stop_level > efs_pkg::ONE_LEVEL) ? efs_pkg::ONE_LEVEL : c.stop_level;
        fading   = 1'b0;
        lvl      = v;
        from_lvl = v;
        to_lvl   = v;
        expect_level(v, 1'b1);
      end
      default: advance_fade();
    endcase
  endtask

  task automatic check_level(input efs_pkg::rsp_t got);
    efs_pkg::rsp_t want;
    if (pending_levels.size() == 0) begin
      report_mismatch("unexpected rsp transaction, level", got.level, 0);
      return;
    end
    want = pending_levels.pop_front();
    if (got.level !== want.level)
      report_mismatch("rsp level", got.level, want.level);
    if (got.finished !== want.finished)
      report_mismatch("rsp finished", got.finished, want.finished);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      mismatches = 0;
      in_ms      = efs_pkg::FADE_IN_RESET;
      out_ms     = efs_pkg::FADE_OUT_RESET;
      tick_ms    = efs_pkg::TICK_RESET;
      lvl        = '0;
      from_lvl   = '0;
      to_lvl     = '0;
      fading     = 1'b0;
      elapsed_ms = '0;
      span_ms    = efs_pkg::DUR_W'(1);
      pending_levels.delete();
    end else begin
      if (rsp_valid && !rsp_stall)
        check_level(rsp);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          efs_pkg::REG_FADE_IN:  in_ms   = cfg_data;
          efs_pkg::REG_FADE_OUT: out_ms  = cfg_data;
          efs_pkg::REG_TICK:     tick_ms = cfg_data[efs_pkg::TICK_W-1:0];
          default: ;
        endcase
      end
      if (cmd_valid && !cmd_stall)
        predict_fade_step(cmd);
    end
    outstanding = pending_levels.size();
  end

endmodule

// ===== dv/eased_fade_sequencer_tb.sv =====
// Top of the eased fade sequencer testbench: clock, reset, command and register
// stimulus with random gaps and stalls, and the final verdict.
// Depends on efs_pkg, eased_fade_sequencer and efs_checker.
module eased_fade_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned      CYCLE_LIMIT     = 1_000_000;
  localparam int               DRAIN_CYCLES    = 80;
  localparam int               ITEMS_PER_PHASE = 190;
  localparam int               PHASES          = 8;
  // Index with no register behind it
  localparam logic [efs_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                           clk;
  logic                           rst;
  logic                           cmd_valid;
  logic                           cmd_stall;
  efs_pkg::cmd_t                  cmd;
  logic                           rsp_valid;
  logic                           rsp_stall;
  efs_pkg::rsp_t                  rsp;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [efs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [efs_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             mismatches;
  int                             outstanding;
  int unsigned                    cycles;

  eased_fade_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  efs_checker fade_check (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_stall   (cmd_stall),
    .cmd         (cmd),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver stalls: calm stretches, short stalls and a few long ones
  initial begin
    int hold;
    int r;
    rsp_stall = 1'b0;
    hold      = 0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          rsp_stall <= 1'b0;
          hold = $urandom_range(0, 12);
        end else if (r < 62) begin
          rsp_stall <= 1'b0;
          hold = $urandom_range(100, 300);
        end else if (r < 96) begin
          rsp_stall <= 1'b1;
          hold = $urandom_range(0, 3);
        end else begin
          rsp_stall <= 1'b1;
          hold = $urandom_range(20, 60);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65)
      return 0;
    if (r < 93)
      return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_cmd(input efs_pkg::op_t op,
                          input logic [efs_pkg::LEVEL_W-1:0] stop_lvl);
    efs_pkg::cmd_t nxt;
    int            gap;
    gap = pick_gap();
    // Idle cycles carry noise on the payload
    repeat (gap) begin
      @(negedge clk);
      nxt.op         = efs_pkg::op_t'($urandom_range(0, 3));
      nxt.stop_level = efs_pkg::LEVEL_W'($urandom);
      cmd_valid <= 1'b0;
      cmd       <= nxt;
    end
    @(negedge clk);
    nxt.op         = op;
    nxt.stop_level = stop_lvl;
    cmd_valid <= 1'b1;
    cmd       <= nxt;
    do @(posedge clk); while (cmd_stall);
  endtask

  task automatic write_reg(input logic [efs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [efs_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [efs_pkg::DUR_W-1:0] in_ms,
                           input logic [efs_pkg::DUR_W-1:0] out_ms,
                           input logic [efs_pkg::TICK_W-1:0] tick_ms);
    write_reg(efs_pkg::REG_FADE_IN, in_ms);
    write_reg(efs_pkg::REG_FADE_OUT, out_ms);
    // Upper data bits fall outside the tick register
    write_reg(efs_pkg::REG_TICK, {6'($urandom), tick_ms});
  endtask

  // Hold off until every report is back and the last command has drained
  task automatic wait_idle();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (outstanding != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [efs_pkg::LEVEL_W-1:0] pick_stop_level();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return efs_pkg::ONE_LEVEL;
      2:       return efs_pkg::LEVEL_W'($urandom_range(0, efs_pkg::ONE_LEVEL));
      default: return efs_pkg::LEVEL_W'($urandom);
    endcase
  endfunction

  task automatic run_phase(input int ph);
    logic [efs_pkg::DUR_W-1:0]  in_ms;
    logic [efs_pkg::DUR_W-1:0]  out_ms;
    logic [efs_pkg::TICK_W-1:0] tick_ms;
    int                         sent;
    int                         burst_max;
    int                         burst;
    int                         r;
    case (ph)
      0: begin in_ms = 16'hFFFF; out_ms = '0;       tick_ms = efs_pkg::TICK_W'(1000); end
      1: begin in_ms = 16'd1;    out_ms = 16'hFFFF; tick_ms = '1; end
      2: begin in_ms = 16'd3;    out_ms = 16'd5;    tick_ms = efs_pkg::TICK_W'(1); end
      3: begin in_ms = 16'd90;   out_ms = 16'd40;   tick_ms = '0; end
      default: begin
        in_ms   = efs_pkg::DUR_W'($urandom_range(0, 400));
        out_ms  = efs_pkg::DUR_W'($urandom_range(0, 400));
        tick_ms = efs_pkg::TICK_W'($urandom_range(5, 60));
      end
    endcase
    configure(in_ms, out_ms, tick_ms);
    if (tick_ms == '0)
      burst_max = 6;
    else
      burst_max = ((in_ms > out_ms ? in_ms : out_ms) / tick_ms) + 2;
    if (burst_max > 80)
      burst_max = 80;
    sent = 0;
    while (sent < ITEMS_PER_PHASE) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_cmd(efs_pkg::OP_SHOW, efs_pkg::LEVEL_W'($urandom));
      else if (r < 80)
        send_cmd(efs_pkg::OP_HIDE, efs_pkg::LEVEL_W'($urandom));
      else if (r < 90)
        send_cmd(efs_pkg::OP_STOP, pick_stop_level());
      else
        send_cmd(efs_pkg::OP_TICK, efs_pkg::LEVEL_W'($urandom));
      sent++;
      // Mostly a long burst of ticks, up to burst_max, else a short one of up to three
      if ($urandom_range(0, 99) < 60)
        burst = $urandom_range(0, burst_max);
      else
        burst = $urandom_range(0, 3);
      if (burst > ITEMS_PER_PHASE - sent)
        burst = ITEMS_PER_PHASE - sent;
      repeat (burst) begin
        send_cmd(efs_pkg::OP_TICK, efs_pkg::LEVEL_W'($urandom));
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst       = 1'b1;
    cmd_valid = 1'b0;
    cmd       = '0;
    cfg_valid = 1'b0;
    cfg_index = efs_pkg::REG_FADE_IN;
    cfg_data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: idle tick, no-op hide, repeated show, reversal, stops
    send_cmd(efs_pkg::OP_TICK, '1);
    send_cmd(efs_pkg::OP_HIDE, '0);
    send_cmd(efs_pkg::OP_SHOW, '0);
    send_cmd(efs_pkg::OP_SHOW, '1);
    repeat (4) send_cmd(efs_pkg::OP_TICK, '0);
    send_cmd(efs_pkg::OP_HIDE, '0);
    repeat (2) send_cmd(efs_pkg::OP_TICK, '0);
    send_cmd(efs_pkg::OP_STOP, '1);
    send_cmd(efs_pkg::OP_SHOW, '0);
    send_cmd(efs_pkg::OP_STOP, efs_pkg::ONE_LEVEL - 1'b1);
    send_cmd(efs_pkg::OP_STOP, '0);
    wait_idle();

    // Zero duration counts as one, spare index takes no effect
    configure('0, 16'd40, '1);
    write_reg(REG_SPARE, 16'hFFFF);
    send_cmd(efs_pkg::OP_SHOW, '0);
    send_cmd(efs_pkg::OP_TICK, '0);
    send_cmd(efs_pkg::OP_HIDE, '0);
    send_cmd(efs_pkg::OP_TICK, '0);
    wait_idle();

    // Zero tick period freezes the fade
    write_reg(efs_pkg::REG_TICK, '0);
    send_cmd(efs_pkg::OP_SHOW, '0);
    send_cmd(efs_pkg::OP_TICK, '0);
    send_cmd(efs_pkg::OP_TICK, '0);
    send_cmd(efs_pkg::OP_STOP, efs_pkg::ONE_LEVEL >> 1);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++)
      run_phase(ph);

    for (int w = 0; w < 20000 && outstanding != 0; w++)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
